### src/nhhf_pkg.sv
// nhhf_pkg: shared constants, types and header byte function of the hop header framer
// no dependencies; imported by every module under src
package nhhf_pkg;

    localparam int MAX_HOPS     = 4;
    localparam int HEADER_BYTES = 16;
    localparam int HOP_REGS     = 4;
    localparam int NUM_HOPS     = (MAX_HOPS < HOP_REGS) ? MAX_HOPS : HOP_REGS;

    localparam int CNT_W  = 3;
    localparam int HOP_W  = $clog2(HOP_REGS);
    localparam int POS_W  = $clog2(HEADER_BYTES);
    localparam int LEN_W  = 32;
    localparam int HVAL_W = 48;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_HOP_COUNT = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_HOP_FIRST = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_HOP_LAST  = IDX_W'(HOP_REGS);

    // request codes
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_HDR
    } t_state;

    typedef struct packed {
        logic load_pay;
        logic start;
        logic emit_hdr;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic hops_zero;
        logic hdr_last;
    } t_sts;

    // one byte of a routing header: address, port, zero word, length
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HVAL_W-1:0] hop,
                                                  input logic [LEN_W-1:0]  len,
                                                  input logic [POS_W-1:0]  pos);
        logic [31:0] word;
        logic [BYTE_W-1:0] b;
        case (pos[3:2])
            2'd0:    word = hop[47:16];
            2'd1:    word = {16'h0000, hop[15:0]};
            2'd2:    word = 32'h0000_0000;
            default: word = len;
        endcase
        case (pos[1:0])
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

endpackage

### src/nhhf_ctrl.sv
// nhhf_ctrl: controller state machine of the hop header framer
// depends on nhhf_pkg; drives commands to nhhf_dp and reads its status
module nhhf_ctrl
    import nhhf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_req_type,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_sts.slot_free && i_req_type == REQ_START && !i_sts.hops_zero)
                    n_state = ST_HDR;
            end
            ST_HDR: begin
                if (i_sts.slot_free && i_sts.hdr_last)
                    n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = i_sts.slot_free;
                if (i_valid && i_sts.slot_free) begin
                    if (i_req_type == REQ_PAYLOAD)
                        o_cmd.load_pay = 1'b1;
                    else
                        o_cmd.start = 1'b1;
                end
            end
            ST_HDR: begin
                o_cmd.emit_hdr = i_sts.slot_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

`ifndef SYNTH
    a_no_accept_in_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HDR) |-> (!o_cmd.start && !o_cmd.load_pay))
        else $error("input beat taken during header run");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_hdr |-> i_sts.slot_free)
        else $error("header byte emitted into a full output slot");

    a_start_enters_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.start && !i_sts.hops_zero) |=> (r_state == ST_HDR))
        else $error("start with hops did not begin a header run");

    a_hdr_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_hdr && i_sts.hdr_last) |=> (r_state == ST_IDLE))
        else $error("header run did not end after the goal header");
`endif

endmodule

### src/nhhf_dp.sv
// nhhf_dp: datapath of the hop header framer: config registers, counters, output register
// depends on nhhf_pkg; commanded by nhhf_ctrl
module nhhf_dp
    import nhhf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [HVAL_W-1:0] i_cfg_data,
    input  logic [LEN_W-1:0]  i_payload_length,
    input  logic [BYTE_W-1:0] i_payload_byte,
    input  logic              i_payload_last,
    input  logic              i_ready,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_is_header,
    output logic              o_last_of_run
);

    logic [CNT_W-1:0]  r_hop_count;
    logic [HVAL_W-1:0] r_hops [HOP_REGS];
    logic [HOP_W-1:0]  r_hop;
    logic [POS_W-1:0]  r_pos;
    logic [LEN_W-1:0]  r_len;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_hdr;
    logic              r_out_last;

    logic [CNT_W-1:0]  w_active;
    logic [CNT_W-1:0]  w_top;
    logic [LEN_W-1:0]  w_len;
    logic [IDX_W-1:0]  w_slot;
    logic              w_pos_end;

    // configuration writes, beyond the list ignored
    assign w_slot = i_cfg_index - REG_HOP_FIRST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop_count <= '0;
            for (int i = 0; i < HOP_REGS; i++) r_hops[i] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_HOP_COUNT)
                r_hop_count <= i_cfg_data[CNT_W-1:0];
            else if (i_cfg_index >= REG_HOP_FIRST && i_cfg_index <= REG_HOP_LAST)
                r_hops[w_slot[HOP_W-1:0]] <= i_cfg_data;
        end
    end

    assign w_active  = (r_hop_count > CNT_W'(NUM_HOPS)) ? CNT_W'(NUM_HOPS) : r_hop_count;
    assign w_top     = w_active - CNT_W'(1);
    assign w_pos_end = (r_pos == POS_W'(HEADER_BYTES - 1));
    // enclosed length of the current hop
    assign w_len     = r_len + (LEN_W'(r_hop) << POS_W);

    // hop and byte counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hop <= w_top[HOP_W-1:0];
            r_pos <= '0;
            r_len <= i_payload_length;
        end else if (i_cmd.emit_hdr) begin
            r_pos <= r_pos + POS_W'(1);
            if (w_pos_end)
                r_hop <= r_hop - HOP_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_pay || i_cmd.emit_hdr) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pay) begin
            r_out_byte <= i_payload_byte;
            r_out_hdr  <= 1'b0;
            r_out_last <= i_payload_last;
        end else if (i_cmd.emit_hdr) begin
            r_out_byte <= hdr_byte(r_hops[r_hop], w_len, r_pos);
            r_out_hdr  <= 1'b1;
            r_out_last <= o_sts.hdr_last;
        end
    end

    assign o_sts.slot_free = !r_out_valid || i_ready;
    assign o_sts.hops_zero = (w_active == '0);
    assign o_sts.hdr_last  = (r_hop == '0) && w_pos_end;

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_header   = r_out_hdr;
    assign o_last_of_run = r_out_last;

endmodule

### src/nested_hop_header_framer.sv
// nested_hop_header_framer: top level, joins controller and datapath
// depends on nhhf_pkg, nhhf_ctrl and nhhf_dp
//
// usage
// - input channel i_valid / o_ready carries one beat per item: a start beat
//   (req_type 0) with the payload length, or a payload beat (req_type 1)
// - output channel o_valid / i_ready carries one framed byte per beat
// - a start beat makes 16 header bytes per active hop, outermost hop first,
//   the goal hop last with last_of_run set on its final byte
// - payload beats pass through the output register, one per cycle unless stalled
// - header bytes leave at one per cycle unless stalled; a start beat with hops
//   holds the input off while the hop and byte counters step through its headers
// - with zero hops a start beat is absorbed and makes no output
// - an output register parts the two sides: a new beat is taken in the same
//   cycle the waiting byte is taken by the receiver
// - receiver stall holds the output byte and stops the header run in place
// - reset clears the hop count, the hop registers and the output valid
// - config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once and
//   belong to idle periods only
module nested_hop_header_framer
    import nhhf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config port
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [HVAL_W-1:0] i_cfg_data,
    // input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_req_type,
    input  logic [LEN_W-1:0]  i_payload_length,
    input  logic [BYTE_W-1:0] i_payload_byte,
    input  logic              i_payload_last,
    // output channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_is_header,
    output logic              o_last_of_run
);

    t_cmd w_cmd;
    t_sts w_sts;

    // state machine: idle taking beats, or running headers
    nhhf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_ready    (o_ready)
    );

    // hop registers, counters, header byte select and output register
    nhhf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .i_payload_last   (i_payload_last),
        .i_ready          (i_ready),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_valid          (o_valid),
        .o_out_byte       (o_out_byte),
        .o_is_header      (o_is_header),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

### tb/sv/testbench.sv
// testbench for nested_hop_header_framer: directed and random framing traffic,
// each output byte checked against an in-bench prediction of the header runs
// depends on nhhf_pkg and the framer RTL under src
module testbench
    import nhhf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int ITEM_TARGET  = 460;
    localparam int IDLE_TAIL    = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BEATS  = 45;

    // one framed output byte as the receiver should see it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              hdr;
        logic              last;
    } t_framed_byte;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [HVAL_W-1:0] i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic              i_req_type;
    logic [LEN_W-1:0]  i_payload_length;
    logic [BYTE_W-1:0] i_payload_byte;
    logic              i_payload_last;
    logic              o_valid;
    logic              i_ready;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_is_header;
    logic              o_last_of_run;

    // shadow copy of the framer registers
    logic [CNT_W-1:0]  shadow_hop_count;
    logic [HVAL_W-1:0] shadow_hops [HOP_REGS];

    t_framed_byte frame_q [$];
    int mismatch_cnt = 0;
    int beats_sent   = 0;
    int cycle_cnt    = 0;
    int stall_left   = 0;
    bit idle_in      = 1'b1;
    bit idle_out     = 1'b1;

    nested_hop_header_framer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .i_payload_last   (i_payload_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_byte       (o_out_byte),
        .o_is_header      (o_is_header),
        .o_last_of_run    (o_last_of_run)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // a routing header laid out as one 128-bit word, first byte on top
    function automatic logic [BYTE_W-1:0] route_hdr_byte(input logic [HVAL_W-1:0] hop,
                                                        input logic [LEN_W-1:0]  enc_len,
                                                        input int unsigned       pos);
        logic [127:0] hdr;
        hdr = {hop[47:16], 16'h0000, hop[15:0], 32'h0000_0000, enc_len};
        return hdr[127 - 8*pos -: 8];
    endfunction

    // hop count saturates at the number of hop registers
    function automatic int unsigned hops_in_use();
        int unsigned n;
        n = 32'(shadow_hop_count);
        if (n > NUM_HOPS)
            n = NUM_HOPS;
        return n;
    endfunction

    // queue up every byte one accepted beat makes
    function automatic void frame_item(input logic req, input logic [LEN_W-1:0] plen,
                                       input logic [BYTE_W-1:0] pbyte, input logic plast);
        t_framed_byte fb;
        logic [LEN_W-1:0] enc_len;
        int unsigned j;
        if (req == REQ_PAYLOAD) begin
            fb.data = pbyte;
            fb.hdr  = 1'b0;
            fb.last = plast;
            frame_q.push_back(fb);
        end else begin
            // outermost hop first, each one encloses the headers inside it
            for (int h = hops_in_use(); h > 0; h--) begin
                j = h - 1;
                enc_len = plen + LEN_W'(HEADER_BYTES * j);
                for (int p = 0; p < HEADER_BYTES; p++) begin
                    fb.data = route_hdr_byte(shadow_hops[j], enc_len, p);
                    fb.hdr  = 1'b1;
                    fb.last = (j == 0) && (p == HEADER_BYTES - 1);
                    frame_q.push_back(fb);
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // output side: random stalls and checking
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_framed_byte got;
        t_framed_byte want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_out_byte, o_is_header, o_last_of_run};
            if (frame_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("unexpected beat: byte %h header %b last %b",
                             got.data, got.hdr, got.last);
            end else begin
                want = frame_q.pop_front();
                if (got.data !== want.data || got.hdr !== want.hdr
                        || got.last !== want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("mismatch: byte exp %h got %h, header exp %b got %b, ",
                                 want.data, got.data, want.hdr, got.hdr,
                                 "last exp %b got %b", want.last, got.last);
                end
            end
            // receiver draws its stall before the next beat
            stall_left = idle_out ? $urandom_range(0, 4) : 0;
        end
    end

    // ------------------------------------------------------------------
    // input side helpers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [HVAL_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        if (idx == REG_HOP_COUNT)
            shadow_hop_count = val[CNT_W-1:0];
        else if (idx >= REG_HOP_FIRST && idx <= REG_HOP_LAST)
            shadow_hops[HOP_W'(idx - REG_HOP_FIRST)] = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // one input beat: random gap, hold until taken, then predict
    task automatic send_beat(input logic req, input logic [LEN_W-1:0] plen,
                             input logic [BYTE_W-1:0] pbyte, input logic plast);
        int gap;
        gap = idle_in ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_req_type       = req;
        i_payload_length = plen;
        i_payload_byte   = pbyte;
        i_payload_last   = plast;
        do
            @(posedge i_clk);
        while (!o_ready);
        frame_item(req, plen, pbyte, plast);
        beats_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // unused fields of each kind carry random junk
    task automatic send_start(input logic [LEN_W-1:0] plen);
        send_beat(REQ_START, plen, BYTE_W'($urandom), 1'($urandom));
    endtask

    task automatic send_payload(input logic [BYTE_W-1:0] pbyte, input logic plast);
        send_beat(REQ_PAYLOAD, LEN_W'($urandom), pbyte, plast);
    endtask

    // every expected byte out, then the IDLE_TAIL wait for absorbed starts
    task automatic wait_framer_idle();
        while (frame_q.size() != 0)
            @(negedge i_clk);
        repeat (IDLE_TAIL) @(negedge i_clk);
    endtask

    function automatic logic [HVAL_W-1:0] random_hop();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values: no hops, so starts vanish and payload passes straight through
    task automatic test_reset_defaults();
        send_start(LEN_W'(5));
        send_payload(8'h00, 1'b0);
        send_payload(8'hFF, 1'b1);
        wait_framer_idle();
    endtask

    // single goal hop, all ones, both length extremes
    task automatic test_single_hop();
        write_reg(REG_HOP_FIRST, '1);
        write_reg(REG_HOP_COUNT, HVAL_W'(1));
        send_start('0);
        send_start('1);
        send_payload(8'hA5, 1'b1);
        wait_framer_idle();
    endtask

    // all four hops, outer lengths wrap past 2^32
    task automatic test_four_hops_wrap();
        write_reg(REG_HOP_FIRST,              48'hC0A8_0001_1F90);
        write_reg(REG_HOP_FIRST + IDX_W'(1),  '0);
        write_reg(REG_HOP_FIRST + IDX_W'(2),  '1);
        write_reg(REG_HOP_LAST,               48'h0A00_00FF_0050);
        write_reg(REG_HOP_COUNT, HVAL_W'(NUM_HOPS));
        send_start(32'hFFFF_FFF0);
        send_start('0);
        send_payload(8'h3C, 1'b1);
        wait_framer_idle();
    endtask

    // oversized counts saturate, stray indexes and upper data bits are dropped
    task automatic test_count_limits();
        write_reg(REG_HOP_COUNT, HVAL_W'(NUM_HOPS + 1));
        send_start(LEN_W'(100));
        wait_framer_idle();
        write_reg(REG_HOP_COUNT, '1);
        send_start(LEN_W'(7));
        wait_framer_idle();
        for (int idx = REG_HOP_LAST + 1; idx < (1 << IDX_W); idx++)
            write_reg(IDX_W'(idx), '1);
        send_start(LEN_W'(1));
        wait_framer_idle();
        // only the low three bits count, so this means zero hops
        write_reg(REG_HOP_COUNT, 48'hFFFF_FFFF_FFF8);
        send_start(LEN_W'(3));
        send_payload(8'h01, 1'b0);
        wait_framer_idle();
    endtask

    // zero-valued hops still make full headers
    task automatic test_zero_hops_used();
        write_reg(REG_HOP_FIRST, '0);
        write_reg(REG_HOP_FIRST + IDX_W'(1), '0);
        write_reg(REG_HOP_COUNT, HVAL_W'(2));
        send_start(LEN_W'(2));
        send_payload(8'h80, 1'b0);
        wait_framer_idle();
    endtask

    // sender holds off mid-packet until the header run has fully drained
    task automatic test_sender_pause();
        write_reg(REG_HOP_COUNT, HVAL_W'(NUM_HOPS));
        idle_out = 1'b1;
        send_start(LEN_W'(1));
        wait_framer_idle();
        send_payload(8'h7E, 1'b1);
        wait_framer_idle();
    endtask

    // packets with random content, a new setting every few dozen beats
    task automatic test_random_traffic();
        int phase;
        int phase_start;
        int n;
        int r;
        logic [LEN_W-1:0] plen;
        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            wait_framer_idle();
            for (int h = 0; h < HOP_REGS; h++)
                write_reg(REG_HOP_FIRST + IDX_W'(h), random_hop());
            write_reg(REG_HOP_COUNT, {16'($urandom), 32'($urandom)});
            // phase picks which sides idle; one in four runs flat out
            idle_in  = (phase % 4 == 0) || (phase % 4 == 2);
            idle_out = (phase % 4 == 0) || (phase % 4 == 1);
            phase_start = beats_sent;
            while (beats_sent < ITEM_TARGET && beats_sent - phase_start < PHASE_BEATS) begin
                r = $urandom_range(0, 15);
                if (r < 12) begin
                    // well formed: start then its payload, last on the final byte
                    n = $urandom_range(0, 6);
                    plen = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : LEN_W'(n);
                    send_start(plen);
                    for (int i = 0; i < n; i++)
                        send_payload(BYTE_W'($urandom), i == n - 1);
                end else if (r < 14) begin
                    send_payload(BYTE_W'($urandom), 1'($urandom));
                end else if (r == 14) begin
                    send_start(LEN_W'($urandom));
                end else begin
                    send_start(LEN_W'($urandom_range(0, 64)));
                    wait_framer_idle();
                end
            end
            phase++;
        end
        idle_in  = 1'b1;
        idle_out = 1'b1;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = REG_HOP_COUNT;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_req_type       = REQ_START;
        i_payload_length = '0;
        i_payload_byte   = '0;
        i_payload_last   = 1'b0;
        i_ready          = 1'b1;
        shadow_hop_count = '0;
        for (int h = 0; h < HOP_REGS; h++)
            shadow_hops[h] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_single_hop();
        test_four_hops_wrap();
        test_count_limits();
        test_zero_hops_used();
        test_sender_pause();
        test_random_traffic();

        wait_framer_idle();
        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
src/nhhf_pkg.sv
src/nhhf_ctrl.sv
src/nhhf_dp.sv
src/nested_hop_header_framer.sv
tb/sv/testbench.sv
